// ----- hdl/rct_pkg.sv -----
package rct_pkg;

  localparam int NODE_COUNT_DEF = 32;
  localparam int VALUE_W        = 5;
  localparam int BITS_W         = 32;
  localparam logic [VALUE_W-1:0] HIGHEST_RESET = 5'd31;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_UNCONST = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_CLOSE
  } fsm_state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic last;
  } cell_ctl_t;

endpackage

// ----- hdl/rct_if.sv -----
interface rct_item_if;
  import rct_pkg::*;
  logic                 valid;
  logic                 ready;
  action_t              action;
  logic [VALUE_W-1:0]   source_value;
  logic [VALUE_W-1:0]   target_value;
  modport source (output valid, action, source_value, target_value, input ready);
  modport sink   (input valid, action, source_value, target_value, output ready);
endinterface

interface rct_result_if;
  import rct_pkg::*;
  logic                valid;
  logic                ready;
  logic [BITS_W-1:0]   reach_bits;
  status_t             status;
  modport source (output valid, reach_bits, status, input ready);
  modport sink   (input valid, reach_bits, status, output ready);
endinterface

interface rct_cfg_if;
  import rct_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  highest_value;
  modport source (output valid, highest_value, input ready);
  modport sink   (input valid, highest_value, output ready);
endinterface

// ----- hdl/rct_cell.sv -----
module rct_cell import rct_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int CELL_INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctl_t                     ctl,
  input  logic [$clog2(NODE_COUNT)-1:0] col,
  input  logic [NODE_COUNT-1:0]         pivot,
  input  logic [NODE_COUNT-1:0]         neighbor,
  input  logic                          wr_en,
  input  logic [NODE_COUNT-1:0]         wr_bits,
  input  logic                          self_keep,
  output logic [NODE_COUNT-1:0]         row,
  output logic [NODE_COUNT-1:0]         upd
);

  localparam logic [NODE_COUNT-1:0] SELF_BIT =
    {{(NODE_COUNT-1){1'b0}}, 1'b1} << CELL_INDEX;

  logic [NODE_COUNT-1:0] row_next;

  // warshall step on the row held here, pivot row comes from the head cell
  assign upd = row[col] ? (row | pivot) : row;

  always_comb begin
    priority if (ctl.clear) begin
      row_next = '0;
    end else if (ctl.shift) begin
      row_next = neighbor | ((ctl.last && self_keep) ? SELF_BIT : '0);
    end else if (wr_en) begin
      row_next = row | wr_bits;
    end else begin
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

endmodule

// ----- hdl/reachability_closure_table.sv -----
// add, query and clear: result valid in the cycle after the item is taken, one item
//   per cycle while no result is stalled; close: the rows circulate once around
//   the cell chain, each step applying the row at the head as pivot to every row
// no item is taken while a close runs; configuration writes are taken at any time
// synchronous reset clears the matrix and the present mask and sets
//   highest_value to 31, with no clearing pass
module reachability_closure_table import rct_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rct_item_if.sink      req,
  rct_result_if.source  rsp,
  rct_cfg_if.sink       cfg
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam logic [6:0] NODE_LIM = 7'(NODE_COUNT);
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(NODE_COUNT - 1);
  localparam logic [NODE_COUNT-1:0] ONE = {{(NODE_COUNT-1){1'b0}}, 1'b1};

  fsm_state_t             state, state_next;
  logic [IDX_W-1:0]       k;
  logic [VALUE_W-1:0]     highest;
  logic [NODE_COUNT-1:0]  present;
  logic [NODE_COUNT-1:0]  present_next;
  logic [NODE_COUNT-1:0]  rows [NODE_COUNT];
  logic [NODE_COUNT-1:0]  upds [NODE_COUNT];
  logic [NODE_COUNT-1:0]  wr_en;
  logic [NODE_COUNT-1:0]  dst_bits;
  logic [NODE_COUNT-1:0]  src_bits;
  cell_ctl_t              cell_ctl;

  logic                   in_ready;
  logic                   in_acc;
  logic                   k_last;
  logic                   src_ok;
  logic                   dst_ok;
  logic                   add_ok;
  logic [IDX_W-1:0]       src_idx;
  logic [IDX_W-1:0]       dst_idx;
  logic [32:0]            span;
  logic [63:0]            row_ext;

  logic                   out_valid;
  logic [BITS_W-1:0]      out_bits;
  status_t                out_status;
  logic                   res_load;
  logic [BITS_W-1:0]      res_bits;
  status_t                res_status;

  assign in_acc  = req.valid && in_ready;
  assign k_last  = (k == K_LAST);
  assign src_idx = IDX_W'(req.source_value);
  assign dst_idx = IDX_W'(req.target_value);
  assign src_ok  = (req.source_value <= highest) && (7'(req.source_value) < NODE_LIM);
  assign dst_ok  = (req.target_value <= highest) && (7'(req.target_value) < NODE_LIM);
  assign add_ok  = in_acc && (req.action == ACT_ADD) && src_ok && dst_ok;
  assign src_bits = ONE << src_idx;
  assign dst_bits = ONE << dst_idx;
  assign wr_en   = add_ok ? src_bits : '0;

  for (genvar j = 0; j < NODE_COUNT; j++) begin : g_cell
    rct_cell #(
      .NODE_COUNT (NODE_COUNT),
      .CELL_INDEX (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .col       (k),
      .pivot     (rows[0]),
      .neighbor  (upds[(j + 1) % NODE_COUNT]),
      .wr_en     (wr_en[j]),
      .wr_bits   (dst_bits),
      .self_keep (present[j]),
      .row       (rows[j]),
      .upd       (upds[j])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && req.action == ACT_CLOSE) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (k_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready       = 1'b0;
    cell_ctl.clear = 1'b0;
    cell_ctl.shift = 1'b0;
    cell_ctl.last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = !out_valid || rsp.ready;
        cell_ctl.clear = req.valid && in_ready && (req.action == ACT_CLEAR);
      end
      S_CLOSE: begin
        cell_ctl.shift = 1'b1;
        cell_ctl.last  = k_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    present_next = present;
    if (cell_ctl.clear) begin
      present_next = '0;
    end else if (add_ok) begin
      present_next = present | src_bits | dst_bits;
    end
  end

  assign span    = (33'd2 << highest) - 33'd1;
  assign row_ext = 64'(rows[src_idx]);

  always_comb begin
    res_bits   = '0;
    res_status = STAT_OK;
    res_load   = cell_ctl.last;
    if (in_acc) begin
      unique case (req.action)
        ACT_ADD: begin
          res_load = 1'b1;
          if (!(src_ok && dst_ok)) begin
            res_status = STAT_RANGE;
          end
        end
        ACT_QUERY: begin
          res_load = 1'b1;
          priority if (present == '0) begin
            res_status = STAT_UNCONST;
          end else if (!src_ok) begin
            res_status = STAT_RANGE;
          end else if (!present[src_idx]) begin
            res_status = STAT_UNKNOWN;
          end else begin
            res_bits = row_ext[BITS_W-1:0] & span[BITS_W-1:0];
          end
        end
        ACT_CLEAR: res_load = 1'b1;
        ACT_CLOSE: res_load = 1'b0;
        default:   res_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      highest   <= HIGHEST_RESET;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      present <= present_next;
      if (state == S_CLOSE) begin
        k <= k_last ? '0 : k + 1'b1;
      end
      if (cfg.valid) begin
        highest <= cfg.highest_value;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_bits   <= res_bits;
      out_status <= res_status;
    end
  end

  assign req.ready      = in_ready;
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = out_valid;
  assign rsp.reach_bits = out_bits;
  assign rsp.status     = out_status;

endmodule

// ----- hdl/rct_checker.sv -----
module rct_checker import rct_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input action_t            req_action,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [BITS_W-1:0]  rsp_reach_bits,
  input status_t            rsp_status
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> !rsp_valid || rsp_ready)
    else $error("item taken while a result is stalled");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_action != ACT_CLOSE |=> rsp_valid)
    else $error("missing result one cycle after item");

  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_action == ACT_CLOSE |=> !req_ready)
    else $error("item taken during close");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_OK |-> rsp_reach_bits == '0)
    else $error("nonzero bitmap with error status");

endmodule

bind reachability_closure_table rct_checker u_rct_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_action     (req.action),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_reach_bits (rsp.reach_bits),
  .rsp_status     (rsp.status)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import rct_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 7;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [BITS_W-1:0] reach_bits;
    status_t           status;
  } reach_answer_t;

  logic clk = 1'b0;
  logic rst;

  rct_item_if   req_if();
  rct_result_if rsp_if();
  rct_cfg_if    cfg_if();

  reachability_closure_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // shadow copy of the table
  logic [BITS_W-1:0] shadow_rows [NODE_COUNT_DEF];
  logic [BITS_W-1:0] shadow_present;
  value_t            shadow_highest;

  reach_answer_t awaited_answers [$];
  value_t        edge_pool [8];
  int            items_sent;
  int            mismatch_count;
  int            cycle_count;
  logic          no_idle;
  logic          rsp_hold = 1'b0;
  event          start_hold;

  function automatic logic in_range(value_t v);
    return v <= shadow_highest;
  endfunction

  function automatic reach_answer_t table_answer(action_t act, value_t src, value_t dst);
    reach_answer_t ans;
    logic [BITS_W:0] mask;
    ans.reach_bits = '0;
    ans.status     = STAT_OK;
    case (act)
      ACT_ADD: begin
        if (!in_range(src) || !in_range(dst)) begin
          ans.status = STAT_RANGE;
        end else begin
          shadow_rows[src][dst] = 1'b1;
          shadow_present[src]   = 1'b1;
          shadow_present[dst]   = 1'b1;
        end
      end
      ACT_CLOSE: begin
        for (int k = 0; k < NODE_COUNT_DEF; k++) begin
          for (int i = 0; i < NODE_COUNT_DEF; i++) begin
            if (shadow_rows[i][k]) begin
              shadow_rows[i] = shadow_rows[i] | shadow_rows[k];
            end
          end
        end
        for (int i = 0; i < NODE_COUNT_DEF; i++) begin
          if (shadow_present[i]) begin
            shadow_rows[i][i] = 1'b1;
          end
        end
      end
      ACT_QUERY: begin
        if (shadow_present == '0) begin
          ans.status = STAT_UNCONST;
        end else if (!in_range(src)) begin
          ans.status = STAT_RANGE;
        end else if (!shadow_present[src]) begin
          ans.status = STAT_UNKNOWN;
        end else begin
          mask = ({{BITS_W{1'b0}}, 1'b1} << (shadow_highest + 1)) - 1'b1;
          ans.reach_bits = shadow_rows[src] & mask[BITS_W-1:0];
        end
      end
      default: begin
        for (int i = 0; i < NODE_COUNT_DEF; i++) begin
          shadow_rows[i] = '0;
        end
        shadow_present = '0;
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_item(action_t act, value_t src, value_t dst);
    logic took;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.source_value <= src;
    req_if.target_value <= dst;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = req_if.ready;
      @(posedge clk);
    end
    awaited_answers.insert(awaited_answers.size(), table_answer(act, src, dst));
    items_sent++;
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (awaited_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_highest(value_t hv);
    logic took;
    drain_answers();
    cfg_if.valid         <= 1'b1;
    cfg_if.highest_value <= hv;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end
    cfg_if.valid   <= 1'b0;
    shadow_highest = hv;
  endtask

  function automatic value_t pick_node();
    if ($urandom_range(9) == 0) begin
      return value_t'($urandom_range(31));
    end
    return edge_pool[$urandom_range(7)];
  endfunction

  function automatic value_t pick_origin();
    value_t j;
    j = value_t'($urandom_range(31));
    if (shadow_present != '0 && $urandom_range(3) != 0) begin
      while (!shadow_present[j]) begin
        j = j + 1'b1;
      end
    end
    return j;
  endfunction

  task automatic run_closure_sequence();
    int n;
    for (int k = 0; k < 8; k++) begin
      edge_pool[k] = value_t'($urandom_range(shadow_highest));
    end
    if ($urandom_range(9) < 8) begin
      send_item(ACT_CLEAR, value_t'($urandom_range(31)), value_t'($urandom_range(31)));
    end
    if ($urandom_range(9) == 0) begin
      send_item(ACT_QUERY, pick_origin(), value_t'($urandom_range(31)));
    end
    n = $urandom_range(14, 1);
    for (int k = 0; k < n; k++) begin
      send_item(ACT_ADD, pick_node(), pick_node());
    end
    if ($urandom_range(9) < 8) begin
      send_item(ACT_CLOSE, value_t'($urandom_range(31)), value_t'($urandom_range(31)));
    end
    if ($urandom_range(9) < 3) begin
      n = $urandom_range(4, 1);
      for (int k = 0; k < n; k++) begin
        send_item(ACT_ADD, pick_node(), pick_node());
      end
      if ($urandom_range(1) == 0) begin
        send_item(ACT_CLOSE, value_t'($urandom_range(31)), value_t'($urandom_range(31)));
      end
    end
    n = $urandom_range(6, 1);
    for (int k = 0; k < n; k++) begin
      send_item(ACT_QUERY, pick_origin(), value_t'($urandom_range(31)));
    end
    if ($urandom_range(9) == 0) begin
      send_item(action_t'($urandom_range(3)), value_t'($urandom_range(31)),
                value_t'($urandom_range(31)));
    end
  endtask

  task automatic test_directed_chain();
    send_item(ACT_QUERY, 5'd0, 5'd31);
    send_item(ACT_CLEAR, 5'd31, 5'd0);
    send_item(ACT_ADD, 5'd0, 5'd1);
    send_item(ACT_ADD, 5'd1, 5'd2);
    send_item(ACT_ADD, 5'd2, 5'd31);
    send_item(ACT_ADD, 5'd31, 5'd31);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd3, 5'd0);
    send_item(ACT_CLOSE, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd31);
    send_item(ACT_QUERY, 5'd31, 5'd0);
    send_item(ACT_CLOSE, 5'd31, 5'd31);
    send_item(ACT_ADD, 5'd31, 5'd0);
    send_item(ACT_CLOSE, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd2, 5'd0);
  endtask

  task automatic test_directed_range();
    write_highest(5'd4);
    send_item(ACT_ADD, 5'd5, 5'd0);
    send_item(ACT_ADD, 5'd0, 5'd5);
    send_item(ACT_QUERY, 5'd5, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    write_highest(5'd0);
    send_item(ACT_ADD, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd1, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_CLEAR, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd31, 5'd31);
  endtask

  task automatic test_random_tables();
    value_t hv_plan [8] = '{5'd31, 5'd0, 5'd15, 5'd31, 5'd1, 5'd7, 5'd30, 5'd31};
    int phase;
    int stop_at;
    int phase_end;
    phase   = 0;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      write_highest(phase < 8 ? hv_plan[phase] : value_t'($urandom_range(31)));
      no_idle   = (phase == 3);
      phase_end = items_sent + 75;
      while (items_sent < phase_end) begin
        run_closure_sequence();
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    write_highest(5'd31);
    no_idle = 1'b1;
    -> start_hold;
    send_item(ACT_CLEAR, 5'd0, 5'd0);
    for (int k = 0; k < 40; k++) begin
      case (k % 8)
        7:       send_item(ACT_CLOSE, value_t'($urandom_range(31)), 5'd0);
        3, 5:    send_item(ACT_QUERY, pick_origin(), value_t'($urandom_range(31)));
        default: send_item(ACT_ADD, value_t'($urandom_range(7)), value_t'($urandom_range(7)));
      endcase
    end
    no_idle = 1'b0;
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !rsp_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always begin
    @(start_hold);
    @(negedge clk);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rsp_hold = 1'b0;
  end

  always @(negedge clk) begin : result_check
    reach_answer_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result bits=%h status=%s",
                                  rsp_if.reach_bits, rsp_if.status.name()));
      end else begin
        want = awaited_answers.pop_front();
        if (rsp_if.reach_bits !== want.reach_bits) begin
          report_mismatch($sformatf("reach_bits got %h want %h",
                                    rsp_if.reach_bits, want.reach_bits));
        end
        if (rsp_if.status !== want.status) begin
          report_mismatch($sformatf("status got %s want %s",
                                    rsp_if.status.name(), want.status.name()));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("reachability_closure_table verification failed");
    $finish;
  end

  initial begin
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ADD;
    req_if.source_value  = '0;
    req_if.target_value  = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.highest_value = '0;
    no_idle              = 1'b0;
    items_sent           = 0;
    mismatch_count       = 0;
    shadow_present       = '0;
    shadow_highest       = HIGHEST_RESET;
    for (int i = 0; i < NODE_COUNT_DEF; i++) begin
      shadow_rows[i] = '0;
    end
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_chain();
    test_directed_range();
    test_random_tables();
    test_output_stall();

    drain_answers();
    repeat (NODE_COUNT_DEF + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("reachability_closure_table verification clean");
    end else begin
      $display("reachability_closure_table verification failed");
    end
    $finish;
  end

endmodule
